### design/tpcsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcsc_pkg
// Shared types, constants and the CRC-16 byte update for the text packet
// CRC and sequence checker.
// ----------------------------------------------------------------------------
package tpcsc_pkg;

    localparam int SEQ_WIDTH = 16;

    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [16:0] CRC_POISON = 17'h1FFFF;
    localparam logic [16:0] CRC_SAT    = 17'h10000;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    // Word counter values.
    localparam logic [1:0] WORD_CRC = 2'd1;
    localparam logic [1:0] WORD_TAG = 2'd2;
    localparam logic [1:0] WORD_SEQ = 2'd3;

    typedef struct packed {
        logic [15:0] next_expected;
        logic [15:0] received_seq;
        logic [15:0] computed_crc;
        logic        seq_ok;
        logic        crc_ok;
        logic        accepted;
    } res_t;

    // Per-line parser state.
    typedef struct packed {
        logic [15:0]          crc;
        logic [1:0]           word_count;
        logic                 inside_word;
        logic                 past_third;
        logic [16:0]          crc_field;
        logic                 crc_field_valid;
        logic [SEQ_WIDTH-1:0] seq_field;
        logic                 seq_valid;
        logic                 seq_overflow;
        logic                 line_ended;
    } line_t;

    // CRC-16, MSB first, no reflection, one byte.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### design/text_packet_crc_sequence_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_packet_crc_sequence_checker_core
// Parses a received text line byte by byte, runs a CRC-16 over words two
// onward and checks the CRC word and the sequence number at the last byte.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata                              tuser/tlast
// s_axis    in         [7:0] data_byte                    tlast: last_byte
// m_axis    out        [0] accepted [1] crc_ok [2] seq_ok  none
//                      [18:3] computed_crc [34:19] received_seq
//                      [50:35] next_expected, rest zero
//
// One byte per cycle while s_tready is high. A byte is held in an input register,
// then the parser and CRC update write the line state and, on the last byte, a
// result into a three-entry output queue. s_tready drops only when queued
// results plus the byte in flight fill the queue. Reset clears the line state,
// the expected sequence number and the queue.
// ----------------------------------------------------------------------------
module text_packet_crc_sequence_checker_core
    import tpcsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // accepted, crc_ok, seq_ok, computed_crc,
                                              // received_seq, next_expected, zero fill
);

    localparam logic [1:0] QUEUE_DEPTH = 2'd3;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    line_t                line_reg, line_next;
    logic [SEQ_WIDTH-1:0] expected_reg, expected_next;

    res_t                 queue_reg [3];
    logic [1:0]           wr_ptr_reg, rd_ptr_reg, count_reg;
    res_t                 result;
    logic                 push, pop;

    logic [2:0]           occupancy;
    assign occupancy = {1'b0, count_reg} + {2'b00, in_valid_reg};
    assign s_tready  = occupancy < {1'b0, QUEUE_DEPTH};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    // Parser and checker.
    always_comb
    begin
        line_t                ln;
        logic                 digit;
        logic [3:0]           d;
        logic [20:0]          crc_prod;
        logic [SEQ_WIDTH+3:0] seq_prod;
        logic                 crc_ok, seq_ok, acc;
        logic [31:0]          seq_ext, exp_ext;

        ln       = line_reg;
        digit    = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
        d        = digit ? 4'(in_byte_reg - CHAR_ZERO) : 4'd0;
        crc_prod = ({4'd0, ln.crc_field} << 3) + ({4'd0, ln.crc_field} << 1) + 21'(d);
        seq_prod = ({4'd0, ln.seq_field} << 3) + ({4'd0, ln.seq_field} << 1)
                   + (SEQ_WIDTH+4)'(d);

        if (!ln.line_ended)
        begin
            if (in_byte_reg == CHAR_LF || in_byte_reg == CHAR_CR || in_byte_reg == CHAR_NUL)
            begin
                ln.line_ended  = 1'b1;
                ln.inside_word = 1'b0;
            end
            else if (in_byte_reg == CHAR_SPACE)
            begin
                ln.inside_word = 1'b0;
            end
            else
            begin
                if (!ln.inside_word)
                begin
                    ln.inside_word = 1'b1;
                    // Words after the first are joined by one space in the CRC.
                    if (ln.word_count >= WORD_TAG)
                    begin
                        ln.crc = crc_feed(ln.crc, CHAR_SPACE);
                    end
                    if (ln.word_count == WORD_SEQ)
                    begin
                        ln.past_third = 1'b1;
                    end
                    else
                    begin
                        ln.word_count = ln.word_count + 2'd1;
                    end
                end
                if (ln.word_count >= WORD_TAG)
                begin
                    ln.crc = crc_feed(ln.crc, in_byte_reg);
                end

                if (ln.word_count == WORD_CRC)
                begin
                    if (digit)
                    begin
                        ln.crc_field_valid = 1'b1;
                        if (!ln.crc_field[16])
                        begin
                            ln.crc_field = (|crc_prod[20:16]) ? CRC_SAT : crc_prod[16:0];
                        end
                    end
                    else
                    begin
                        ln.crc_field = CRC_POISON;
                    end
                end
                else if (ln.word_count == WORD_SEQ && !ln.past_third)
                begin
                    if (digit)
                    begin
                        ln.seq_valid = 1'b1;
                        if (!ln.seq_overflow)
                        begin
                            if (|seq_prod[SEQ_WIDTH+3:SEQ_WIDTH])
                            begin
                                ln.seq_overflow = 1'b1;
                            end
                            else
                            begin
                                ln.seq_field = seq_prod[SEQ_WIDTH-1:0];
                            end
                        end
                    end
                    else
                    begin
                        ln.seq_overflow = 1'b1;
                    end
                end
            end
        end

        crc_ok  = ln.crc_field_valid && !ln.crc_field[16] && (ln.crc_field[15:0] == ln.crc);
        seq_ok  = ln.seq_valid && !ln.seq_overflow && (ln.seq_field == expected_reg);
        acc     = crc_ok && seq_ok;
        seq_ext = 32'(ln.seq_field);

        expected_next = expected_reg;
        if (in_valid_reg && in_last_reg && acc)
        begin
            expected_next = expected_reg + SEQ_WIDTH'(1);
        end
        exp_ext = 32'(expected_next);

        result.accepted      = acc;
        result.crc_ok        = crc_ok;
        result.seq_ok        = seq_ok;
        result.computed_crc  = ln.crc;
        if (!ln.seq_valid)
        begin
            result.received_seq = 16'd0;
        end
        else if (ln.seq_overflow || (|seq_ext[31:16]))
        begin
            result.received_seq = 16'hFFFF;
        end
        else
        begin
            result.received_seq = seq_ext[15:0];
        end
        result.next_expected = exp_ext[15:0];

        line_next = line_reg;
        if (in_valid_reg)
        begin
            line_next = in_last_reg ? '0 : ln;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= '0;
            expected_reg <= '0;
        end
        else
        begin
            line_reg     <= line_next;
            expected_reg <= expected_next;
        end
    end

    // Output queue.
    assign push     = in_valid_reg && in_last_reg;
    assign m_tvalid = count_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_DEPTH - 2'd1) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_DEPTH - 2'd1) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= result;
        end
    end

    assign m_tdata = {5'd0, queue_reg[rd_ptr_reg]};

endmodule

### design/tpcsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcsc_checker
// Port-level checks for the text packet CRC and sequence checker.
// ----------------------------------------------------------------------------
module tpcsc_checker
    import tpcsc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic        seen_reg;
    logic [15:0] prev_expected_reg;
    logic        out_xfer;

    assign out_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg          <= 1'b0;
            prev_expected_reg <= 16'd0;
        end
        else if (out_xfer)
        begin
            seen_reg          <= 1'b1;
            prev_expected_reg <= m_tdata[50:35];
        end
    end

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_accept_implies_checks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[0] || (m_tdata[1] && m_tdata[2])))
        else $error("accepted without both checks passing");

    // A matching sequence number must be the one the expected count came from.
    a_seq_matches_expected: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[34:19] == m_tdata[50:35] - {15'd0, m_tdata[0]})
        else $error("seq_ok inconsistent with next_expected");

    // The expected count moves only by one accepted packet between results.
    a_expected_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && seen_reg |-> m_tdata[50:35] == prev_expected_reg + {15'd0, m_tdata[0]})
        else $error("expected sequence number jumped between results");

endmodule

bind text_packet_crc_sequence_checker_core tpcsc_checker u_tpcsc_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds text packet lines into the CRC and sequence checker one byte per
// transfer and compares every verdict with a line parser kept in the bench.
// Directed lines cover number limits, malformed words, missing words,
// spacing and line endings. Random lines follow, mostly well formed, with
// random stalls on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module testbench;
    import tpcsc_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    res_t       pending_verdicts[$];
    logic [7:0] line_buf[$];
    int         errors;
    int         bytes_sent;
    bit         idle_on;
    int         hold_req;

    // Line parser state kept by the bench.
    logic [SEQ_WIDTH-1:0] pred_expected_seq;
    logic [15:0]          pred_crc;
    logic [1:0]           pred_words;
    bit                   pred_in_word;
    bit                   pred_past_seq;
    logic [16:0]          pred_crc_word;
    bit                   pred_crc_seen;
    logic [SEQ_WIDTH-1:0] pred_seq_word;
    bit                   pred_seq_seen;
    bit                   pred_seq_bad;
    bit                   pred_ended;

    text_packet_crc_sequence_checker_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // CRC-16 with polynomial 0x8005, shifted in one bit at a time, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [15:0] text_crc(input string s);
        logic [15:0] c;
        c = 16'h0000;
        for (int i = 0; i < s.len(); i++)
            c = crc16_byte(c, s[i]);
        return c;
    endfunction

    task automatic clear_line_state();
        pred_crc      = 16'h0000;
        pred_words    = 2'd0;
        pred_in_word  = 1'b0;
        pred_past_seq = 1'b0;
        pred_crc_word = 17'h0;
        pred_crc_seen = 1'b0;
        pred_seq_word = '0;
        pred_seq_seen = 1'b0;
        pred_seq_bad  = 1'b0;
        pred_ended    = 1'b0;
    endtask

    // Advances the line parser by one accepted byte and queues the verdict
    // when the byte closes the datagram.
    task automatic parse_line_byte(input logic [7:0] b, input logic last);
        logic                 is_digit;
        logic [3:0]           dval;
        logic [20:0]          wide;
        logic [SEQ_WIDTH+4:0] wide_seq;
        res_t                 r;
        is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        dval     = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;
        if (!pred_ended)
        begin
            if (b == CHAR_LF || b == CHAR_CR || b == CHAR_NUL)
            begin
                pred_ended   = 1'b1;
                pred_in_word = 1'b0;
            end
            else if (b == CHAR_SPACE)
            begin
                pred_in_word = 1'b0;
            end
            else
            begin
                if (!pred_in_word)
                begin
                    pred_in_word = 1'b1;
                    // Words after the CRC word are joined by exactly one space.
                    if (pred_words >= WORD_TAG)
                        pred_crc = crc16_byte(pred_crc, CHAR_SPACE);
                    if (pred_words == WORD_SEQ)
                        pred_past_seq = 1'b1;
                    if (pred_words < WORD_SEQ)
                        pred_words = pred_words + 2'd1;
                end
                if (pred_words >= WORD_TAG)
                    pred_crc = crc16_byte(pred_crc, b);
                if (pred_words == WORD_CRC)
                begin
                    if (is_digit)
                    begin
                        pred_crc_seen = 1'b1;
                        if (pred_crc_word <= 17'h0FFFF)
                        begin
                            wide          = pred_crc_word * 21'd10 + 21'(dval);
                            pred_crc_word = (wide > 21'h0FFFF) ? CRC_SAT : wide[16:0];
                        end
                    end
                    else
                    begin
                        pred_crc_word = CRC_POISON;
                    end
                end
                else if (pred_words == WORD_SEQ && !pred_past_seq)
                begin
                    if (is_digit)
                    begin
                        pred_seq_seen = 1'b1;
                        if (!pred_seq_bad)
                        begin
                            wide_seq = (SEQ_WIDTH+5)'(pred_seq_word) * (SEQ_WIDTH+5)'(10)
                                       + (SEQ_WIDTH+5)'(dval);
                            if (wide_seq > {SEQ_WIDTH{1'b1}})
                                pred_seq_bad = 1'b1;
                            else
                                pred_seq_word = wide_seq[SEQ_WIDTH-1:0];
                        end
                    end
                    else
                    begin
                        pred_seq_bad = 1'b1;
                    end
                end
            end
        end
        if (last)
        begin
            r.computed_crc = pred_crc;
            r.crc_ok   = pred_crc_seen && (pred_crc_word <= 17'h0FFFF) &&
                         (pred_crc_word[15:0] == pred_crc);
            r.seq_ok   = pred_seq_seen && !pred_seq_bad &&
                         (pred_seq_word == pred_expected_seq);
            r.accepted = r.crc_ok && r.seq_ok;
            if (!pred_seq_seen)
                r.received_seq = 16'h0000;
            else if (pred_seq_bad)
                r.received_seq = 16'hFFFF;
            else
                r.received_seq = (pred_seq_word > 16'hFFFF) ? 16'hFFFF : 16'(pred_seq_word);
            if (r.accepted)
                pred_expected_seq = pred_expected_seq + SEQ_WIDTH'(1);
            r.next_expected = 16'(pred_expected_seq);
            pending_verdicts.push_back(r);
            clear_line_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_on && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_line_byte(b, last);
        bytes_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic put_spaces();
        repeat (($urandom_range(4) == 0) ? $urandom_range(3, 2) : 1)
            put_byte(CHAR_SPACE);
    endtask

    // Sends the buffered bytes as one datagram, tlast on the final byte.
    task automatic flush_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic string good_crc(input string body);
        return $sformatf("%0d", text_crc(body));
    endfunction

    // A word of random bytes that are neither separators nor line ends.
    function automatic string rand_word(input int lo, input int hi);
        string      w;
        logic [7:0] c;
        int         n;
        w = "";
        n = $urandom_range(hi, lo);
        repeat (n)
        begin
            do
                c = 8'($urandom_range(255, 1));
            while (c == CHAR_LF || c == CHAR_CR || c == CHAR_SPACE);
            w = $sformatf("%s%c", w, c);
        end
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_verdict(input logic [OUT_TDATA_W-1:0] d);
        res_t want;
        res_t got;
        if (pending_verdicts.size() == 0)
        begin
            $error("verdict transfer with none expected: %h", d);
            errors++;
        end
        else
        begin
            want = pending_verdicts.pop_front();
            got  = res_t'(d[$bits(res_t)-1:0]);
            check_field("accepted", want.accepted, got.accepted);
            check_field("crc_ok", want.crc_ok, got.crc_ok);
            check_field("seq_ok", want.seq_ok, got.seq_ok);
            check_field("computed_crc", want.computed_crc, got.computed_crc);
            check_field("received_seq", want.received_seq, got.received_seq);
            check_field("next_expected", want.next_expected, got.next_expected);
            check_field("zero_fill", 0, d[OUT_TDATA_W-1:$bits(res_t)]);
        end
    endtask

    // Output side: checks each verdict transfer and drives tready.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_verdict(m_tdata);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
            end
        end
    end

    task automatic test_directed();
        string body;

        // Well-formed packets, accepted, with both line end styles.
        body = $sformatf("D %0d hello", pred_expected_seq);
        put_str({good_crc(body), " ", body});
        put_byte(CHAR_LF);
        flush_line();
        body = $sformatf("D %0d", pred_expected_seq);
        put_str({good_crc(body), " ", body});
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
        flush_line();

        // Good CRC, wrong sequence number; then good sequence, wrong CRC.
        body = $sformatf("D %0d x", 16'(pred_expected_seq + 5));
        put_str({good_crc(body), " ", body});
        flush_line();
        body = $sformatf("D %0d y", pred_expected_seq);
        put_str({$sformatf("%0d", text_crc(body) ^ 16'h0001), " ", body});
        flush_line();

        // CRC word out of range or not a number.
        put_str("65536 A 0");
        flush_line();
        put_str("123456789 A 0");
        flush_line();
        put_str("12a D 0");
        flush_line();
        put_str("a12 D 0");
        flush_line();

        // Missing words: CRC word alone, empty line, a lone space.
        put_str("0");
        put_byte(CHAR_LF);
        flush_line();
        put_str("123");
        flush_line();
        put_byte(CHAR_LF);
        flush_line();
        put_byte(CHAR_SPACE);
        flush_line();

        // Sequence word at the limit, above it, and with a non-digit.
        body = "T 65535";
        put_str({good_crc(body), " ", body});
        flush_line();
        body = "T 65536";
        put_str({good_crc(body), " ", body});
        flush_line();
        body = "T 4x";
        put_str({good_crc(body), " ", body});
        flush_line();
        body = "T x4";
        put_str({good_crc(body), " ", body});
        flush_line();

        // Runs of spaces, leading and trailing, collapse in the CRC.
        body = $sformatf("D %0d a b", pred_expected_seq);
        put_str({"  ", good_crc(body), "   D   ", $sformatf("%0d", pred_expected_seq),
                 "  a   b  "});
        put_byte(CHAR_LF);
        flush_line();

        // A zero byte ends the line; the bytes after it are ignored.
        body = $sformatf("D %0d z", pred_expected_seq);
        put_str({good_crc(body), " ", body});
        put_byte(CHAR_NUL);
        put_str("99 junk");
        put_byte(8'hFF);
        flush_line();

        // No line end at all, high bytes in the data word, leading zeros.
        body = $sformatf("Q %06d %c%c", pred_expected_seq, 8'hFF, 8'h80);
        put_str({good_crc(body), " ", body});
        flush_line();

        wait_drained();
    endtask

    task automatic send_random_line();
        string       parts[$];
        string       body;
        string       crc_txt;
        int          pick;
        int          n;
        logic [15:0] crc;

        pick = $urandom_range(99);
        if (pick < 12)
        begin
            n = $urandom_range(12, 1);
            repeat (n)
                put_byte(8'($urandom_range(255)));
            flush_line();
            return;
        end

        parts.push_back(rand_word(1, 4));
        pick = $urandom_range(99);
        if (pick < 70)
            parts.push_back($sformatf("%0d", pred_expected_seq));
        else if (pick < 75)
            parts.push_back($sformatf("%06d", pred_expected_seq));
        else if (pick < 85)
            parts.push_back($sformatf("%0d", $urandom_range(65535)));
        else if (pick < 92)
            parts.push_back($sformatf("%0d", $urandom_range(9999999, 65536)));
        else
            parts.push_back(rand_word(1, 3));
        repeat ($urandom_range(3))
            parts.push_back(rand_word(1, 6));

        // Now and then a line that stops short of the sequence word.
        if ($urandom_range(19) == 0)
        begin
            n = $urandom_range(1);
            while (parts.size() > n)
                void'(parts.pop_back());
        end

        body = "";
        foreach (parts[i])
            body = (i == 0) ? parts[i] : {body, " ", parts[i]};
        crc = text_crc(body);

        pick = $urandom_range(99);
        if (pick < 85)
            crc_txt = $sformatf("%0d", crc);
        else if (pick < 92)
            crc_txt = $sformatf("%0d", crc ^ (16'h0001 << $urandom_range(15)));
        else if (pick < 96)
            crc_txt = $sformatf("%0d", $urandom_range(99999));
        else
            crc_txt = rand_word(1, 3);

        if ($urandom_range(9) == 0)
            put_spaces();
        put_str(crc_txt);
        foreach (parts[i])
        begin
            put_spaces();
            put_str(parts[i]);
        end
        if ($urandom_range(9) == 0)
            put_spaces();

        pick = $urandom_range(5);
        case (pick)
            1, 2: put_byte(CHAR_LF);
            3:    put_byte(CHAR_CR);
            4:
            begin
                put_byte(CHAR_CR);
                put_byte(CHAR_LF);
            end
            5:    put_byte(CHAR_NUL);
            default: ;
        endcase
        if (pick != 0 && $urandom_range(4) == 0)
            repeat ($urandom_range(5, 1))
                put_byte(8'($urandom_range(255)));
        flush_line();
    endtask

    task automatic test_random_lines(input int until_bytes);
        while (bytes_sent < until_bytes)
            send_random_line();
    endtask

    task automatic test_streaming(input int until_bytes);
        idle_on = 1'b0;
        test_random_lines(until_bytes);
        idle_on = 1'b1;
    endtask

    // The output side stalls for a long time while one-byte lines keep
    // coming, so the result queue fills and the input stalls; then the
    // sender waits for every verdict.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 300;
        repeat (30)
        begin
            put_byte($urandom_range(1) ? CHAR_LF : CHAR_ZERO);
            flush_line();
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        errors     = 0;
        bytes_sent = 0;
        idle_on    = 1'b1;
        hold_req   = 0;
        pred_expected_seq = '0;
        clear_line_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_lines(900);
        test_streaming(1300);
        test_backpressure();
        test_random_lines(1650);

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/tpcsc_pkg.sv
design/text_packet_crc_sequence_checker_core.sv
design/tpcsc_checker.sv
bench/testbench.sv
